// ===== hw/rtl/lud_pkg.sv =====
package lud_pkg;

  localparam int IdxW  = 3;
  localparam int AddrW = 6;
  localparam int DataW = 32;
  localparam int DimW  = 4;
  localparam logic [DimW-1:0] DimReset = 4'd8;

  typedef enum logic [2:0] {
    WrElem,
    WrAcc,
    WrRa,
    WrRb,
    WrQuo
  } lud_wsel_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr_a;
    logic [AddrW-1:0] rd_addr_b;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    lud_wsel_e        wr_sel;
    logic             acc_load;
    logic             mul_en;
    logic             sub_en;
    logic             best_clr;
    logic             best_upd;
    logic [IdxW-1:0]  row;
    logic             piv_wr;
    logic [IdxW-1:0]  piv_idx;
    logic             div_start;
    logic             out_load;
    logic             out_sing;
    logic [IdxW-1:0]  out_col;
    logic             out_last;
  } lud_cmd_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] piv;
    logic            div_busy;
    logic            out_free;
  } lud_sts_t;

endpackage

// ===== hw/rtl/lud_ram.sv =====
module lud_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== hw/rtl/lud_div.sv =====
module lud_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lud_pkg::DataW-1:0] dividend_i,
  input  logic [lud_pkg::DataW-1:0] divisor_i,
  output logic                     busy_o,
  output logic [lud_pkg::DataW-1:0] quo_o
);
  import lud_pkg::*;

  localparam int QW = DataW + 16;
  localparam logic [5:0] Steps = 6'(QW);

  logic [QW-1:0]    dvd_q, dvd_d;
  logic [DataW:0]   rem_q, rem_d;
  logic [DataW-1:0] dsr_q, dsr_d;
  logic             neg_q, neg_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DataW:0]   rem_sh;
  logic [DataW-1:0] mag_a, mag_b;

  always_comb begin
    mag_a  = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_b  = divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
    rem_sh = {rem_q[DataW-1:0], dvd_q[QW-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      dvd_d = {mag_a, 16'h0000};
      rem_d = '0;
      dsr_d = mag_b;
      neg_d = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      cnt_d = Steps;
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sh - {1'b0, dsr_q};
        dvd_d = {dvd_q[QW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);

  always_comb begin
    if (neg_q) begin
      if (dvd_q > QW'(32'h8000_0000)) begin
        quo_o = 32'h8000_0000;
      end else begin
        quo_o = 32'h0 - dvd_q[DataW-1:0];
      end
    end else begin
      if (dvd_q > QW'(32'h7FFF_FFFF)) begin
        quo_o = 32'h7FFF_FFFF;
      end else begin
        quo_o = dvd_q[DataW-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/lud_datapath.sv =====
module lud_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lud_pkg::lud_cmd_t         cmd_i,
  output lud_pkg::lud_sts_t         sts_o,
  input  logic [lud_pkg::DataW-1:0] element_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lud_pkg::DataW-1:0] lu_value_o,
  output logic [lud_pkg::IdxW-1:0]  row_index_o,
  output logic [lud_pkg::IdxW-1:0]  col_index_o,
  output logic [lud_pkg::IdxW-1:0]  pivot_row_o,
  output logic                      status_o,
  output logic                      last_o
);
  import lud_pkg::*;

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(MAX_DIM);

  logic [DataW-1:0] ra, rb, wdata, quo;
  logic [DataW-1:0] acc_q, acc_d, prod_q, prod_d, best_q, best_d, mag;
  logic [IdxW-1:0]  piv_q, piv_d;
  logic             found_q, found_d;
  logic [IdxW-1:0]  pstore_q [MAX_DIM];
  logic             div_busy;
  logic             out_valid_q;
  logic             out_free;
  logic signed [63:0] prod_full;
  logic [47:0]        prod_sh;
  logic [DataW:0]     diff;

  lud_ram #(.Width(DataW), .Depth(Depth)) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr_en),
    .waddr_i   (cmd_i.wr_addr[AW-1:0]),
    .wdata_i   (wdata),
    .re_i      (cmd_i.rd_en),
    .raddr_a_i (cmd_i.rd_addr_a[AW-1:0]),
    .raddr_b_i (cmd_i.rd_addr_b[AW-1:0]),
    .rdata_a_o (ra),
    .rdata_b_o (rb)
  );

  lud_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ra),
    .divisor_i  (rb),
    .busy_o     (div_busy),
    .quo_o      (quo)
  );

  always_comb begin
    case (cmd_i.wr_sel)
      WrElem:  wdata = element_i;
      WrAcc:   wdata = acc_q;
      WrRa:    wdata = ra;
      WrRb:    wdata = rb;
      WrQuo:   wdata = quo;
      default: wdata = acc_q;
    endcase
  end

  always_comb begin
    prod_full = $signed(ra) * $signed(rb);
    prod_sh   = prod_full[63:16];
    diff      = {acc_q[DataW-1], acc_q} - {prod_q[DataW-1], prod_q};
    mag       = acc_q[DataW-1] ? (~acc_q + 1'b1) : acc_q;

    if (prod_sh[47:31] == {17{prod_sh[47]}}) begin
      prod_d = prod_sh[DataW-1:0];
    end else begin
      prod_d = prod_sh[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end

    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = ra;
    end else if (cmd_i.sub_en) begin
      if (diff[DataW] == diff[DataW-1]) begin
        acc_d = diff[DataW-1:0];
      end else begin
        acc_d = diff[DataW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end

    best_d  = best_q;
    piv_d   = piv_q;
    found_d = found_q;
    if (cmd_i.best_clr) begin
      best_d  = '0;
      piv_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.best_upd && (mag > best_q)) begin
      best_d  = mag;
      piv_d   = cmd_i.row;
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    best_q  <= best_d;
    piv_q   <= piv_d;
    found_q <= found_d;
    if (cmd_i.piv_wr) begin
      pstore_q[cmd_i.piv_idx[PW-1:0]] <= piv_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      lu_value_o  <= cmd_i.out_sing ? '0 : ra;
      row_index_o <= cmd_i.out_sing ? '0 : cmd_i.row;
      col_index_o <= cmd_i.out_col;
      pivot_row_o <= cmd_i.out_sing ? '0 : pstore_q[cmd_i.row[PW-1:0]];
      status_o    <= cmd_i.out_sing;
      last_o      <= cmd_i.out_sing | cmd_i.out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.found    = found_q;
  assign sts_o.piv      = piv_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = out_free;

endmodule

// ===== hw/rtl/lud_ctrl.sv =====
module lud_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lud_pkg::DimW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lud_pkg::lud_sts_t        sts_i,
  output lud_pkg::lud_cmd_t        cmd_o
);
  import lud_pkg::*;

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_COL  = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_LD   = 5'd3;
  localparam logic [4:0] S_MRD  = 5'd4;
  localparam logic [4:0] S_MMUL = 5'd5;
  localparam logic [4:0] S_MSUB = 5'd6;
  localparam logic [4:0] S_WB   = 5'd7;
  localparam logic [4:0] S_PIV  = 5'd8;
  localparam logic [4:0] S_SWRD = 5'd9;
  localparam logic [4:0] S_SWA  = 5'd10;
  localparam logic [4:0] S_SWB  = 5'd11;
  localparam logic [4:0] S_DRD  = 5'd12;
  localparam logic [4:0] S_DGO  = 5'd13;
  localparam logic [4:0] S_DWT  = 5'd14;
  localparam logic [4:0] S_NXT  = 5'd15;
  localparam logic [4:0] S_ERD  = 5'd16;
  localparam logic [4:0] S_ELD  = 5'd17;
  localparam logic [4:0] S_SING = 5'd18;

  logic [4:0]      state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, lr_q, lr_d, lc_q, lc_d;
  logic            cm_q, cm_d;
  logic [DimW-1:0] dim_q, dim_d, neff;
  logic [IdxW-1:0] nm1, tr, tc;

  function automatic logic [AddrW-1:0] addr(input logic [IdxW-1:0] r,
                                            input logic [IdxW-1:0] c);
    addr = AddrW'(r) * AddrW'(MAX_DIM) + AddrW'(c);
  endfunction

  always_comb begin
    if (dim_q == '0) begin
      neff = DimW'(1);
    end else if (dim_q > DimW'(MAX_DIM)) begin
      neff = DimW'(MAX_DIM);
    end else begin
      neff = dim_q;
    end
    nm1 = IdxW'(neff - DimW'(1));
    tr  = cm_q ? j_q : i_q;
    tc  = cm_q ? i_q : j_q;
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    lr_d       = lr_q;
    lc_d       = lc_q;
    cm_d       = cm_q;
    dim_d      = dim_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.wr_sel = WrElem;

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = addr(lr_q, lc_q);
          if (lc_q == nm1) begin
            lc_d = '0;
            if (lr_q == nm1) begin
              lr_d    = '0;
              i_d     = '0;
              state_d = S_COL;
            end else begin
              lr_d = lr_q + 1'b1;
            end
          end else begin
            lc_d = lc_q + 1'b1;
          end
        end
      end
      S_COL: begin
        cmd_o.best_clr = 1'b1;
        j_d     = i_q;
        cm_d    = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = addr(tr, tc);
        state_d = S_LD;
      end
      S_LD: begin
        cmd_o.acc_load = 1'b1;
        k_d     = '0;
        state_d = (i_q == '0) ? S_WB : S_MRD;
      end
      S_MRD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = addr(tr, k_q);
        cmd_o.rd_addr_b = addr(k_q, tc);
        state_d = S_MMUL;
      end
      S_MMUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_MSUB;
      end
      S_MSUB: begin
        cmd_o.sub_en = 1'b1;
        if (k_q == i_q - 1'b1) begin
          state_d = S_WB;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr(tr, tc);
        cmd_o.wr_sel  = WrAcc;
        cmd_o.row     = j_q;
        cmd_o.best_upd = cm_q;
        if (j_q == nm1) begin
          state_d = cm_q ? S_PIV : S_NXT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_PIV: begin
        if (!sts_i.found) begin
          state_d = S_SING;
        end else begin
          cmd_o.piv_wr  = 1'b1;
          cmd_o.piv_idx = i_q;
          if (sts_i.piv != i_q) begin
            j_d     = '0;
            state_d = S_SWRD;
          end else if (i_q == nm1) begin
            state_d = S_NXT;
          end else begin
            j_d     = i_q + 1'b1;
            state_d = S_DRD;
          end
        end
      end
      S_SWRD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = addr(i_q, j_q);
        cmd_o.rd_addr_b = addr(sts_i.piv, j_q);
        state_d = S_SWA;
      end
      S_SWA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr(i_q, j_q);
        cmd_o.wr_sel  = WrRb;
        state_d = S_SWB;
      end
      S_SWB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr(sts_i.piv, j_q);
        cmd_o.wr_sel  = WrRa;
        if (j_q != nm1) begin
          j_d     = j_q + 1'b1;
          state_d = S_SWRD;
        end else if (i_q == nm1) begin
          state_d = S_NXT;
        end else begin
          j_d     = i_q + 1'b1;
          state_d = S_DRD;
        end
      end
      S_DRD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = addr(j_q, i_q);
        cmd_o.rd_addr_b = addr(i_q, i_q);
        state_d = S_DGO;
      end
      S_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWT;
      end
      S_DWT: begin
        if (!sts_i.div_busy) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = addr(j_q, i_q);
          cmd_o.wr_sel  = WrQuo;
          if (j_q == nm1) begin
            j_d     = i_q + 1'b1;
            cm_d    = 1'b0;
            state_d = S_RD;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_DRD;
          end
        end
      end
      S_NXT: begin
        if (i_q == nm1) begin
          j_d     = '0;
          k_d     = '0;
          state_d = S_ERD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_COL;
        end
      end
      S_ERD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = addr(j_q, k_q);
        state_d = S_ELD;
      end
      S_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.row      = j_q;
          cmd_o.out_col  = k_q;
          cmd_o.out_last = (j_q == nm1) && (k_q == nm1);
          if ((j_q == nm1) && (k_q == nm1)) begin
            state_d = S_LOAD;
          end else begin
            if (k_q == nm1) begin
              k_d = '0;
              j_d = j_q + 1'b1;
            end else begin
              k_d = k_q + 1'b1;
            end
            state_d = S_ERD;
          end
        end
      end
      S_SING: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sing = 1'b1;
          cmd_o.out_col  = i_q;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase

    if (cfg_we_i) begin
      dim_d = cfg_wdata_i;
      lr_d  = '0;
      lc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      lr_q    <= '0;
      lc_q    <= '0;
      cm_q    <= 1'b1;
      dim_q   <= DimReset;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      lr_q    <= lr_d;
      lc_q    <= lc_d;
      cm_q    <= cm_d;
      dim_q   <= dim_d;
    end
  end

endmodule

// ===== hw/rtl/lu_decompose_partial_pivot.sv =====
// Channel | Handshake                | Payload
// cfg     | cfg_we_i                 | cfg_wdata_i (matrix_dim)
// in      | in_valid_i / in_ready_o  | element_i
// out     | out_valid_o / out_ready_i| lu_value_o, row_index_o, col_index_o,
//         |                          | pivot_row_o, status_o, last_o
// Loading accepts one item per cycle while in_ready_o is high; the N*N-th item
// starts the factorization. Each multiply-subtract reads, multiplies and subtracts
// on the one shared multiplier; each division runs in the bit-serial divider.
// No item is accepted from the last load until the final result is registered.
// Reset is asynchronous and active low; the output register holds while stalled.
module lu_decompose_partial_pivot #(
  parameter int MAX_DIM = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lud_pkg::DimW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lud_pkg::DataW-1:0] element_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lud_pkg::DataW-1:0] lu_value_o,
  output logic [lud_pkg::IdxW-1:0]  row_index_o,
  output logic [lud_pkg::IdxW-1:0]  col_index_o,
  output logic [lud_pkg::IdxW-1:0]  pivot_row_o,
  output logic                      status_o,
  output logic                      last_o
);
  import lud_pkg::*;

  lud_cmd_t cmd;
  lud_sts_t sts;

  lud_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lud_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .element_i   (element_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .lu_value_o  (lu_value_o),
    .row_index_o (row_index_o),
    .col_index_o (col_index_o),
    .pivot_row_o (pivot_row_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ===== hw/rtl/lud_chk.sv =====
module lud_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [lud_pkg::DataW-1:0] lu_value_o,
  input logic [lud_pkg::IdxW-1:0]  row_index_o,
  input logic [lud_pkg::IdxW-1:0]  col_index_o,
  input logic [lud_pkg::IdxW-1:0]  pivot_row_o,
  input logic                      status_o,
  input logic                      last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(lu_value_o) && $stable(col_index_o))
    else $error("result changed while stalled");

  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o)
    else $error("singular status not marked last");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> lu_value_o == '0 && row_index_o == '0 &&
    pivot_row_o == '0)
    else $error("singular result carries data");

endmodule

bind lu_decompose_partial_pivot lud_chk u_lud_chk (.*);

// ===== tb/lu_decompose_partial_pivot_test.sv =====
module lu_decompose_partial_pivot_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lud_pkg::*;

  localparam int MaxDim = 8;
  localparam logic signed [DataW-1:0] One = 32'sh0001_0000;

  typedef struct {
    logic [DataW-1:0] value;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [IdxW-1:0]  piv;
    logic             status;
    logic             last;
  } lu_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [DimW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [DataW-1:0]    element_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [DataW-1:0]    lu_value_o;
  logic [IdxW-1:0]     row_index_o;
  logic [IdxW-1:0]     col_index_o;
  logic [IdxW-1:0]     pivot_row_o;
  logic                status_o;
  logic                last_o;

  lu_decompose_partial_pivot #(.MAX_DIM(MaxDim)) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .element_i,
    .out_valid_o,
    .out_ready_i,
    .lu_value_o,
    .row_index_o,
    .col_index_o,
    .pivot_row_o,
    .status_o,
    .last_o
  );

  lu_item_t lu_q[$];
  int errors = 0;
  int sent = 0;
  bit fast_in = 0;
  bit fast_out = 0;
  bit hold_req = 0;

  logic [DimW-1:0]         dim_reg = DimReset;
  logic signed [DataW-1:0] mat[MaxDim*MaxDim];
  logic [IdxW-1:0]         pivots[MaxDim];
  int                      loaded = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string what, input logic [DataW-1:0] got,
                        input logic [DataW-1:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic signed [DataW-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [DataW-1:0] q_mul(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [DataW-1:0] q_sub(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    return sat32(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [DataW-1:0] q_div(input logic signed [DataW-1:0] a,
                                                    input logic signed [DataW-1:0] b);
    if (b == 0) return '0;
    return sat32((longint'(a) * 65536) / longint'(b));
  endfunction

  function automatic longint q_abs(input logic signed [DataW-1:0] v);
    longint w;
    w = v;
    return w < 0 ? -w : w;
  endfunction

  function automatic int cur_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MaxDim) return MaxDim;
    return dim_reg;
  endfunction

  task automatic factor_matrix(input int n);
    longint best;
    int piv;
    bit found;
    logic signed [DataW-1:0] t;
    lu_item_t r;
    for (int i = 0; i < n; i++) begin
      best = 0;
      piv = 0;
      found = 0;
      for (int j = i; j < n; j++) begin
        for (int k = 0; k < i; k++)
          mat[j*MaxDim+i] = q_sub(mat[j*MaxDim+i], q_mul(mat[j*MaxDim+k], mat[k*MaxDim+i]));
        if (q_abs(mat[j*MaxDim+i]) > best) begin
          best = q_abs(mat[j*MaxDim+i]);
          piv = j;
          found = 1;
        end
      end
      if (!found) begin
        r = '{value: '0, row: '0, col: IdxW'(i), piv: '0, status: 1'b1, last: 1'b1};
        lu_q.push_back(r);
        return;
      end
      pivots[i] = IdxW'(piv);
      if (piv != i) begin
        for (int j = 0; j < n; j++) begin
          t = mat[i*MaxDim+j];
          mat[i*MaxDim+j] = mat[piv*MaxDim+j];
          mat[piv*MaxDim+j] = t;
        end
      end
      for (int j = i + 1; j < n; j++)
        mat[j*MaxDim+i] = q_div(mat[j*MaxDim+i], mat[i*MaxDim+i]);
      for (int j = i + 1; j < n; j++)
        for (int k = 0; k < i; k++)
          mat[i*MaxDim+j] = q_sub(mat[i*MaxDim+j], q_mul(mat[i*MaxDim+k], mat[k*MaxDim+j]));
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        r = '{value: mat[i*MaxDim+j], row: IdxW'(i), col: IdxW'(j), piv: pivots[i],
              status: 1'b0, last: (i == n - 1 && j == n - 1)};
        lu_q.push_back(r);
      end
  endtask

  task automatic absorb_element(input logic [DataW-1:0] d);
    int n;
    n = cur_dim();
    if (loaded >= n * n) loaded = 0;
    mat[(loaded / n) * MaxDim + loaded % n] = d;
    loaded++;
    if (loaded == n * n) begin
      factor_matrix(n);
      loaded = 0;
    end
  endtask

  task automatic send_element(input logic [DataW-1:0] d);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_element(d);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (lu_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_dim(input logic [DimW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dim_reg = v;
    loaded = 0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    lu_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lu_q.size() == 0) begin
        report("unexpected result", lu_value_o, '0);
      end else begin
        e = lu_q.pop_front();
        if (lu_value_o !== e.value) report("lu_value", lu_value_o, e.value);
        if (row_index_o !== e.row) report("row_index", row_index_o, e.row);
        if (col_index_o !== e.col) report("col_index", col_index_o, e.col);
        if (pivot_row_o !== e.piv) report("pivot_row", pivot_row_o, e.piv);
        if (status_o !== e.status) report("status", status_o, e.status);
        if (last_o !== e.last) report("last", last_o, e.last);
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 0;
      end
      gap = fast_out ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic logic [DataW-1:0] pick_value(input int kind);
    case (kind)
      0: return '0;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [DataW-1:0] sing3[9];
    write_dim(4'd1);
    send_element('0);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    write_dim(4'd0);
    send_element(32'hffff_ffff);
    write_dim(4'd2);
    send_element('0);
    send_element(One);
    send_element(One);
    send_element('0);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    write_dim(4'd3);
    sing3 = '{One, 2 * One, 3 * One, 2 * One, 4 * One, 6 * One, One, 2 * One, One};
    foreach (sing3[k]) send_element(sing3[k]);
    write_dim(4'd2);
    send_element(One);
    send_element(-One);
    send_element(One);
    send_element(32'h0000_0003);
    send_element(32'h0000_8000);
  endtask

  task automatic test_random();
    logic [DimW-1:0] dims[11] = '{4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd5,
                                  4'd6, 4'd9, 4'd15};
    logic [DimW-1:0] d;
    logic [DataW-1:0] m[MaxDim*MaxDim];
    int n, mats, zero_col, kind;
    write_dim(4'd8);
    fast_in = 1;
    for (int k = 0; k < 64; k++) send_element(pick_value(k % 8 == 0 ? 1 : 3));
    fast_in = 0;
    while (sent < 300) begin
      d = ($urandom_range(0, 5) == 0) ? 4'd8 : dims[$urandom_range(0, 10)];
      write_dim(d);
      fast_in = ($urandom_range(0, 3) == 0);
      fast_out = ($urandom_range(0, 3) == 0);
      n = cur_dim();
      mats = n > 4 ? 1 : $urandom_range(1, 4);
      repeat (mats) begin
        zero_col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int k = 0; k < n * n; k++) begin
          kind = $urandom_range(0, 15);
          kind = kind == 0 ? 0 : kind == 1 ? 1 : kind == 2 ? 2 : 3;
          m[k] = (k % n == zero_col) ? '0 : pick_value(kind);
        end
        if (n > 1 && $urandom_range(0, 4) == 0)
          for (int c = 0; c < n; c++) m[n + c] = m[c];
        for (int k = 0; k < n * n; k++) send_element(m[k]);
      end
      if ($urandom_range(0, 7) == 0) send_element(pick_value(3));
    end
    fast_in = 0;
    fast_out = 0;
  endtask

  task automatic test_backpressure();
    write_dim(4'd4);
    hold_req = 1;
    fast_in = 1;
    for (int k = 0; k < 48; k++) send_element(pick_value(3));
    fast_in = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
